/* hw/rtl/selected_product_mod_accumulator_defines.svh */
// ----------------------------------------------------------------------------
// Selected product modular accumulator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SELECTED_PRODUCT_MOD_ACCUMULATOR_DEFINES_SVH
`define SELECTED_PRODUCT_MOD_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication.
`define SPMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/spma_pkg.sv */
// ----------------------------------------------------------------------------
// spma_pkg
// Constants and shared types of the selected product modular accumulator.
// ----------------------------------------------------------------------------
package spma_pkg;

	localparam int WIDTH   = 64;
	localparam int FIELD_W = 64;
	localparam int CNT_W   = $clog2(WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_reduce;
		logic load_direct;
		logic red_step;
		logic mul_step;
		logic mul_last;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic rp_ge_mod;
	} dp_status_t;

endpackage

/* hw/rtl/spma_datapath.sv */
// ----------------------------------------------------------------------------
// spma_datapath
// Modulus register, running product, restoring reduction and shift-add
// modular multiply, and the result register.
// ----------------------------------------------------------------------------
module spma_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spma_pkg::FIELD_W-1:0]        cfg_wdata,
	input  logic [spma_pkg::FIELD_W-1:0]        value,
	input  spma_pkg::dp_cmd_t                   cmd,
	output spma_pkg::dp_status_t                status,
	output logic [spma_pkg::FIELD_W-1:0]        product
);
	import spma_pkg::*;

	// A modulus of zero stands for 2^WIDTH, hence one extra bit.
	logic [WIDTH:0]   mod_q;
	logic [WIDTH-1:0] rp_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] div_q;
	logic [WIDTH-1:0] out_q;

	logic [WIDTH:0]   rem_ext;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] acc_next;
	logic [WIDTH-1:0] x_dbl;

	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] a,
		input logic [WIDTH-1:0] b,
		input logic [WIDTH:0]   m
	);
		logic [WIDTH:0] s;
		logic [WIDTH:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - m;
		if (s >= m) begin
			return d[WIDTH-1:0];
		end
		return s[WIDTH-1:0];
	endfunction

	assign rem_ext  = {x_q, div_q[WIDTH-1]};
	assign rem_next = (rem_ext >= mod_q) ? WIDTH'(rem_ext - mod_q) : rem_ext[WIDTH-1:0];
	assign acc_next = y_q[0] ? add_mod(acc_q, x_q, mod_q) : acc_q;
	assign x_dbl    = add_mod(x_q, x_q, mod_q);

	assign status.rp_ge_mod = ({1'b0, rp_q} >= mod_q);
	assign product          = FIELD_W'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= (WIDTH+1)'(1);
			rp_q  <= WIDTH'(1);
		end else begin
			if (cfg_we) begin
				mod_q <= {(cfg_wdata[WIDTH-1:0] == '0), cfg_wdata[WIDTH-1:0]};
			end
			if (cmd.mul_last) begin
				rp_q <= acc_next;
			end else if (cmd.emit) begin
				rp_q <= WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_reduce || cmd.load_direct) begin
			y_q   <= value[WIDTH-1:0];
			div_q <= rp_q;
			acc_q <= '0;
			x_q   <= cmd.load_reduce ? '0 : rp_q;
		end else if (cmd.red_step) begin
			x_q   <= rem_next;
			div_q <= {div_q[WIDTH-2:0], 1'b0};
		end else if (cmd.mul_step) begin
			acc_q <= acc_next;
			x_q   <= x_dbl;
			y_q   <= {1'b0, y_q[WIDTH-1:1]};
		end
		if (cmd.emit) begin
			out_q <= rp_q;
		end
	end

endmodule

/* hw/rtl/spma_ctrl.sv */
// ----------------------------------------------------------------------------
// spma_ctrl
// Sequencer for the accumulator: input handshake, bit counter, result
// handshake, and commands to the datapath.
// ----------------------------------------------------------------------------
`include "selected_product_mod_accumulator_defines.svh"

module spma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  selected,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  spma_pkg::dp_status_t  status,
	output spma_pkg::dp_cmd_t     cmd
);
	import spma_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic             cnt_last;
	logic             counting;

	assign cnt_last  = (cnt_q == CNT_W'(WIDTH-1));
	assign counting  = (state_q == ST_REDUCE) || (state_q == ST_MUL);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (counting) begin
				cnt_q <= cnt_last ? '0 : cnt_q + CNT_W'(1);
			end
			if (in_valid && in_ready) begin
				last_q <= last;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (selected) begin
						if (status.rp_ge_mod) begin
							cmd.load_reduce = 1'b1;
							state_d         = ST_REDUCE;
						end else begin
							cmd.load_direct = 1'b1;
							state_d         = ST_MUL;
						end
					end else if (last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (cnt_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_last) begin
					cmd.mul_last = 1'b1;
					state_d      = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`SPMA_ASSERT_IMP(a_idle_cnt_clear, (state_q == ST_IDLE), (cnt_q == '0), "Bit counter not clear in idle.")
	`SPMA_ASSERT_NEXT(a_sel_starts_work, (in_valid && in_ready && selected), (state_q == ST_REDUCE || state_q == ST_MUL), "Selected beat did not start a multiply.")
	`SPMA_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_valid_q, "Emitted result not shown.")
	`SPMA_ASSERT_IMP(a_emit_slot_free, cmd.emit, (!out_valid_q || out_ready), "Result register overwritten.")

endmodule

/* hw/rtl/selected_product_mod_accumulator.sv */
// ----------------------------------------------------------------------------
// selected_product_mod_accumulator
// Running product of selected values modulo a configured modulus.
// ----------------------------------------------------------------------------
// Input beats (value, selected, last) arrive on in_valid/in_ready; results
// (product) leave on out_valid/out_ready. The modulus is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce; zero stands for 2^64. A selected
// beat runs the shift-add multiplier, one multiplier bit per cycle, after a
// restoring reduction when the running product is not below the modulus
// (after a modulus change, or with a modulus of one). A beat marked last
// then loads the result register and out_valid in an emit state, and the
// running product returns to 1. A new beat is taken only while idle, so a
// beat is finished before the next one is accepted.
// Reset sets the modulus and the running product to 1 and clears out_valid.
// When the receiver stalls, the result waits in its register and new beats
// are still taken; only a second result stalls until the first is taken.
// ----------------------------------------------------------------------------
module selected_product_mod_accumulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spma_pkg::FIELD_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [spma_pkg::FIELD_W-1:0]  value,
	input  logic                          selected,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spma_pkg::FIELD_W-1:0]  product
);
	import spma_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	spma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.selected  (selected),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	spma_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.product   (product)
	);

endmodule
